### rtl/akh_pkg.sv
package akh_pkg;

  // Fixed-point format and histogram geometry
  localparam int FRACTION_BITS   = 6;
  localparam int MAX_SPREAD_DEG  = 45;
  localparam int BIN_WIDTH_DEF   = 40;
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int NUM_BINS        = 360;
  localparam int BIN_AW          = 9;
  localparam int ANGLE_W         = 16;
  localparam int SPREAD_W        = 12;
  localparam int SPREAD_RESET    = 704;

  localparam int UNIT_Q  = 1 << FRACTION_BITS;
  localparam int HALF_Q  = 180 << FRACTION_BITS;
  localparam int FULL_Q  = 360 << FRACTION_BITS;
  localparam int QW      = $clog2(FULL_Q);
  localparam int LIMIT_Q = MAX_SPREAD_DEG << FRACTION_BITS;

  // Kernel reach never exceeds MAX_SPREAD_DEG whole bins
  localparam int REACH_W = 7;
  localparam int SPAN_W  = REACH_W + 1;

  localparam int QUEUE_DEPTH = 2;

  // Number of shift-subtract steps that fold a 16-bit magnitude modulo HALF_Q
  function automatic int mod_steps_f();
    int n;
    n = 0;
    for (int k = 0; k < ANGLE_W; k++) begin
      if ((longint'(HALF_Q) << k) <= (longint'(1) << (ANGLE_W - 1))) n = k + 1;
    end
    return (n < 1) ? 1 : n;
  endfunction

  localparam int MOD_STEPS = mod_steps_f();
  localparam int MOD_SW    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // One classified item as it travels from front to back
  typedef struct packed {
    func_t               func;
    logic [QW-1:0]       centre;
    logic [QW-1:0]       spread;
    logic [REACH_W-1:0]  reach;
    logic [BIN_AW-1:0]   bin_index;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_SETUP,
    B_KERN,
    B_DRAIN,
    B_READ,
    B_RDW,
    B_CLEAR,
    B_DONE
  } back_state_t;

endpackage

### rtl/angular_kernel_histogram.sv
// Angular density histogram: 360 one-degree bins built from event angles in
// 1/64-degree units with a triangular kernel at the angle and at angle + 180.
// Input channel (in_valid/in_ready, func, angle_q, bin_index): add an event,
// read one bin or clear the histogram. Every item gives exactly one result on
// the output channel (out_valid/out_ready, bin_value, peak_value,
// event_count). Configuration channel (cfg_valid/cfg_ready, cfg_data) writes
// the kernel half width spread_q; cfg_ready is always high.
// Flow: the front folds an add's angle and then hands the item to a
// two-entry queue. The back does one bin read-modify-write per cycle
// through the bin memory while it walks an add's kernels, with reach =
// ceil(spread/64) whole bins on each side; the reset spread is 11 degrees.
// A read returns one bin; a clear sweeps all 360 bins.
// Reset: spread_q returns to 704 and a clearing pass over all 360 bins
// zeroes them; in_ready stays low until it completes.
// Stall: a waiting result sits in the output register while the back starts
// the next item; the back then holds its finished result, the queue fills
// and the front holds its item. in_ready is high only while the front is
// empty: low from acceptance until the item is pushed to the queue, which
// includes the fold of an add and any wait on a full queue.
module angular_kernel_histogram import akh_pkg::*; #(
  parameter int BIN_WIDTH   = BIN_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic signed [ANGLE_W-1:0]  angle_q,
  input  logic [BIN_AW-1:0]          bin_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [BIN_WIDTH-1:0]       bin_value,
  output logic [BIN_WIDTH-1:0]       peak_value,
  output logic [COUNT_WIDTH-1:0]     event_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [SPREAD_W-1:0]        cfg_data
);

  logic [SPREAD_W-1:0] spread_q;
  logic                front_ready;
  logic                init_busy;
  logic                push_valid;
  logic                push_ready;
  job_t                push_job;
  logic                pop_valid;
  logic                pop_ready;
  job_t                pop_job;

  // Hold the spread register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      spread_q <= SPREAD_W'(SPREAD_RESET);
    end else if (cfg_valid) begin
      spread_q <= cfg_data;
    end
  end

  // Take no item during the clearing pass after reset
  assign in_ready = front_ready && !init_busy;

  akh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid && !init_busy),
    .in_ready   (front_ready),
    .func       (func),
    .angle_q    (angle_q),
    .bin_index  (bin_index),
    .spread_q   (spread_q),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  akh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  akh_back #(
    .BIN_WIDTH   (BIN_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_job     (pop_job),
    .init_busy   (init_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bin_value   (bin_value),
    .peak_value  (peak_value),
    .event_count (event_count)
  );

endmodule

### rtl/akh_ram.sv
module akh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

### rtl/akh_front.sv
module akh_front import akh_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic signed [ANGLE_W-1:0]  angle_q,
  input  logic [BIN_AW-1:0]          bin_index,
  input  logic [SPREAD_W-1:0]        spread_q,
  output logic                       push_valid,
  input  logic                       push_ready,
  output job_t                       push_job
);

  front_state_t             state, state_next;
  job_t                     ent, ent_next;
  logic [ANGLE_W-1:0]       rem, rem_next;
  logic                     neg, neg_next;
  logic [MOD_SW-1:0]        step, step_next;

  logic [SPREAD_W-1:0]      sp_nz;
  logic [QW-1:0]            sp_eff;
  logic [QW:0]              sp_round;
  logic [ANGLE_W-1:0]       mag;
  logic [ANGLE_W+QW-1:0]    div_sh;
  logic [ANGLE_W-1:0]       rem_sub;
  logic [QW-1:0]            fold;

  // Clamp the spread and work out the kernel reach in whole bins
  always_comb begin
    sp_nz    = (spread_q == '0) ? SPREAD_W'(1) : spread_q;
    sp_eff   = (32'(sp_nz) > 32'(LIMIT_Q)) ? QW'(LIMIT_Q) : QW'(sp_nz);
    sp_round = (QW+1)'(sp_eff) + (QW+1)'(UNIT_Q - 1);
  end

  // One restoring step of the fold modulo 180 degrees
  always_comb begin
    mag     = angle_q[ANGLE_W-1] ? ANGLE_W'(-angle_q) : ANGLE_W'(angle_q);
    div_sh  = (ANGLE_W+QW)'(HALF_Q) << step;
    rem_sub = ((ANGLE_W+QW)'(rem) >= div_sh) ? (rem - ANGLE_W'(div_sh)) : rem;
    fold    = (neg && rem != '0) ? (QW'(HALF_Q) - QW'(rem)) : QW'(rem);
  end

  always_comb begin
    push_job        = ent;
    push_job.centre = fold;
  end

  // Accept, fold an add's angle, then hand the item to the queue
  always_comb begin
    state_next = state;
    ent_next   = ent;
    rem_next   = rem;
    neg_next   = neg;
    step_next  = step;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ent_next.func      = func_t'(func);
          ent_next.bin_index = bin_index;
          ent_next.spread    = sp_eff;
          ent_next.reach     = REACH_W'(sp_round >> FRACTION_BITS);
          ent_next.centre    = '0;
          rem_next           = mag;
          neg_next           = angle_q[ANGLE_W-1];
          step_next          = MOD_SW'(MOD_STEPS - 1);
          state_next         = (func_t'(func) == FUNC_ADD) ? F_MOD : F_PUSH;
        end
      end
      F_MOD: begin
        rem_next = rem_sub;
        if (step == '0) state_next = F_PUSH;
        else            step_next  = step - 1'b1;
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
    ent  <= ent_next;
    rem  <= rem_next;
    neg  <= neg_next;
    step <= step_next;
  end

`ifndef SYNTHESIS
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    (state == F_PUSH && ent.func == FUNC_ADD) |-> (32'(rem) < 32'(HALF_Q)))
    else $error("folded angle not below half turn");
`endif

endmodule

### rtl/akh_queue.sv
module akh_queue import akh_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Hold items in arrival order
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill beyond depth");
`endif

endmodule

### rtl/akh_back.sv
module akh_back import akh_pkg::*; #(
  parameter int BIN_WIDTH   = BIN_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  job_t                   pop_job,
  output logic                   init_busy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BIN_WIDTH-1:0]   bin_value,
  output logic [BIN_WIDTH-1:0]   peak_value,
  output logic [COUNT_WIDTH-1:0] event_count
);

  back_state_t             state, state_next;
  job_t                    cur, cur_next;
  logic [QW-1:0]           c, c_next;
  logic                    kern, kern_next;
  logic [BIN_AW-1:0]       idx, idx_next;
  logic [SPAN_W-1:0]       remain, remain_next;
  logic [BIN_AW-1:0]       sweep, sweep_next;
  logic [BIN_WIDTH-1:0]    res_bin, res_bin_next;
  logic [BIN_WIDTH-1:0]    peak, peak_next;
  logic [COUNT_WIDTH-1:0]  count, count_next;
  logic                    out_load;

  // Read-modify-write stage
  logic                    s1_valid, s1_valid_next;
  logic [BIN_AW-1:0]       s1_addr;
  logic [QW-1:0]           s1_w, s1_w_next;
  logic                    byp_hit;
  logic [BIN_WIDTH-1:0]    byp_data;

  // Memory ports
  logic                    rd_en;
  logic [BIN_AW-1:0]       rd_addr;
  logic [BIN_WIDTH-1:0]    ram_q;
  logic                    wr_en;
  logic [BIN_AW-1:0]       wr_addr;
  logic [BIN_WIDTH-1:0]    wr_data;
  logic                    sweeping;

  // Kernel geometry
  logic [QW:0]             c_rnd;
  logic [BIN_AW-1:0]       rounded;
  logic signed [BIN_AW:0]  s_raw;
  logic [BIN_AW-1:0]       start;
  logic [QW-1:0]           idx_q;
  logic [QW:0]             diff;
  logic [QW-1:0]           absd;
  logic [QW-1:0]           cdist;
  logic                    in_rng;
  logic [BIN_WIDTH-1:0]    old_bin;
  logic [BIN_WIDTH:0]      sum;
  logic [BIN_WIDTH-1:0]    b_new;

  akh_ram #(
    .WIDTH (BIN_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // First bin of the current kernel
  always_comb begin
    c_rnd   = (QW+1)'(c) + (QW+1)'(UNIT_Q >> 1);
    rounded = BIN_AW'(c_rnd >> FRACTION_BITS);
    s_raw   = $signed({1'b0, rounded})
              - $signed({{(BIN_AW+1-REACH_W){1'b0}}, cur.reach});
    if (s_raw[BIN_AW]) begin
      start = BIN_AW'(s_raw + (BIN_AW+1)'(NUM_BINS));
    end else if ((BIN_AW+1)'(s_raw) >= (BIN_AW+1)'(NUM_BINS)) begin
      start = BIN_AW'(s_raw - (BIN_AW+1)'(NUM_BINS));
    end else begin
      start = BIN_AW'(s_raw);
    end
  end

  // Circular distance from the current bin to the exact centre
  always_comb begin
    idx_q  = QW'(idx) << FRACTION_BITS;
    diff   = (QW+1)'(idx_q) - (QW+1)'(c);
    absd   = diff[QW] ? QW'(-diff) : QW'(diff);
    cdist  = (absd > QW'(HALF_Q)) ? (QW'(FULL_Q) - absd) : absd;
    in_rng = (cdist <= cur.spread);
    s1_w_next = cur.spread - cdist;
  end

  // Saturating add of the weight onto the bin
  always_comb begin
    old_bin = byp_hit ? byp_data : ram_q;
    sum     = {1'b0, old_bin} + (BIN_WIDTH+1)'(s1_w);
    b_new   = sum[BIN_WIDTH] ? '1 : sum[BIN_WIDTH-1:0];
  end

  assign sweeping = (state == B_INIT) || (state == B_CLEAR);
  assign wr_en    = s1_valid || sweeping;
  assign wr_addr  = sweeping ? sweep : s1_addr;
  assign wr_data  = sweeping ? '0 : b_new;
  assign init_busy = (state == B_INIT);
  assign out_load  = (state == B_DONE) && (!out_valid || out_ready);

  // Sequencer: pop, walk kernels, sweep, read and report
  always_comb begin
    state_next    = state;
    cur_next      = cur;
    c_next        = c;
    kern_next     = kern;
    idx_next      = idx;
    remain_next   = remain;
    sweep_next    = sweep;
    res_bin_next  = res_bin;
    peak_next     = peak;
    count_next    = count;
    s1_valid_next = 1'b0;
    pop_ready     = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx;

    if (s1_valid && b_new > peak) peak_next = b_new;

    unique case (state)
      B_INIT, B_CLEAR: begin
        peak_next  = '0;
        count_next = '0;
        if (sweep == BIN_AW'(NUM_BINS - 1)) begin
          sweep_next = '0;
          state_next = (state == B_INIT) ? B_IDLE : B_DONE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          cur_next     = pop_job;
          c_next       = pop_job.centre;
          kern_next    = 1'b0;
          res_bin_next = '0;
          case (pop_job.func)
            FUNC_ADD:   state_next = B_SETUP;
            FUNC_READ:  state_next = (pop_job.bin_index < BIN_AW'(NUM_BINS)) ? B_READ : B_DONE;
            FUNC_CLEAR: state_next = B_CLEAR;
            default:    state_next = B_DONE;
          endcase
        end
      end
      B_SETUP: begin
        idx_next    = start;
        remain_next = SPAN_W'({cur.reach, 1'b0});
        state_next  = B_KERN;
      end
      B_KERN: begin
        rd_en         = 1'b1;
        s1_valid_next = in_rng;
        idx_next      = (idx == BIN_AW'(NUM_BINS - 1)) ? '0 : idx + 1'b1;
        remain_next   = remain - 1'b1;
        if (remain == '0) begin
          if (!kern) begin
            kern_next  = 1'b1;
            c_next     = c + QW'(HALF_Q);
            state_next = B_SETUP;
          end else begin
            state_next = B_DRAIN;
          end
        end
      end
      B_DRAIN: begin
        if (count != '1) count_next = count + 1'b1;
        state_next = B_DONE;
      end
      B_READ: begin
        rd_en      = 1'b1;
        rd_addr    = cur.bin_index;
        state_next = B_RDW;
      end
      B_RDW: begin
        res_bin_next = ram_q;
        state_next   = B_DONE;
      end
      B_DONE: begin
        if (out_load) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      sweep     <= '0;
      peak      <= '0;
      count     <= '0;
      s1_valid  <= 1'b0;
      byp_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      sweep    <= sweep_next;
      peak     <= peak_next;
      count    <= count_next;
      s1_valid <= s1_valid_next;
      byp_hit  <= s1_valid && rd_en && (s1_addr == rd_addr);
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    cur      <= cur_next;
    c        <= c_next;
    kern     <= kern_next;
    idx      <= idx_next;
    remain   <= remain_next;
    res_bin  <= res_bin_next;
    s1_addr  <= idx;
    s1_w     <= s1_w_next;
    byp_data <= b_new;
    if (out_load) begin
      bin_value   <= res_bin;
      peak_value  <= peak;
      event_count <= count;
    end
  end

`ifndef SYNTHESIS
  a_wr_addr: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_addr < BIN_AW'(NUM_BINS)))
    else $error("bin update outside histogram");

  a_peak_mono: assert property (@(posedge clk) disable iff (rst)
    (state != B_CLEAR && state != B_INIT) |=> (peak >= $past(peak)))
    else $error("peak fell without a clear");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != B_CLEAR && state != B_INIT && state != B_DRAIN) |=> $stable(count))
    else $error("event count moved outside an add");
`endif

endmodule
